// File: rtl/core/bpeb_pkg.sv
// shared types for the bounded priority event buffer
package bpeb_pkg;

  localparam int unsigned PriW  = 16;
  localparam int unsigned TimeW = 64;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    logic [PriW-1:0]  pri;
    logic [TimeW-1:0] start;
    logic [TimeW-1:0] stop;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic append;
    logic scan_clear;
    logic scan_en;
    logic find_max;
    logic replace;
    logic flush_start;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic out_free;
    logic last_pending;
  } dp_sts_t;

endpackage

// File: rtl/core/bpeb_ctrl.sv
// control state machine for the bounded priority event buffer
module bpeb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              cmd_i,
  output logic              in_stall_o,
  input  bpeb_pkg::dp_sts_t sts_i,
  output bpeb_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_ADD_SCAN  = 5'b00010,
    S_ADD_DEC   = 5'b00100,
    S_FL_SCAN   = 5'b01000,
    S_FL_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept     = 1'b1;
          cmd_o.scan_clear = 1'b1;
          if (cmd_i == bpeb_pkg::CMD_ADD) begin
            if (!sts_i.full) begin
              cmd_o.append = 1'b1;
            end else begin
              state_d = S_ADD_SCAN;
            end
          end else if (!sts_i.empty) begin
            cmd_o.flush_start = 1'b1;
            state_d           = S_FL_SCAN;
          end
        end
      end
      S_ADD_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_ADD_DEC;
        end
      end
      S_ADD_DEC: begin
        cmd_o.replace = 1'b1;
        state_d       = S_IDLE;
      end
      S_FL_SCAN: begin
        cmd_o.scan_en  = 1'b1;
        cmd_o.find_max = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FL_EMIT;
        end
      end
      S_FL_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.scan_clear = 1'b1;
          state_d          = sts_i.last_pending ? S_IDLE : S_FL_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/bpeb_dp.sv
// event store, scan comparator and output register
module bpeb_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bpeb_pkg::dp_cmd_t            cmd_i,
  output bpeb_pkg::dp_sts_t            sts_o,
  input  logic [bpeb_pkg::PriW-1:0]    event_priority_i,
  input  logic [bpeb_pkg::TimeW-1:0]   start_time_i,
  input  logic [bpeb_pkg::TimeW-1:0]   stop_time_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bpeb_pkg::PriW-1:0]    out_priority_o,
  output logic [bpeb_pkg::TimeW-1:0]   out_start_o,
  output logic [bpeb_pkg::TimeW-1:0]   out_stop_o,
  output logic                         last_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IdxW-1:0] TopRank = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);

  bpeb_pkg::entry_t ev_mem [CAPACITY];
  bpeb_pkg::entry_t rd_data_q;
  bpeb_pkg::entry_t new_q;
  bpeb_pkg::entry_t best_q;
  bpeb_pkg::entry_t wr_data;

  logic [IdxW-1:0]     rank_q [CAPACITY];
  logic [CAPACITY-1:0] taken_q;
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     scan_q;
  logic [CntW-1:0]     emit_cnt_q;
  logic                rd_vld_q;
  logic [IdxW-1:0]     rd_idx_q;
  logic                found_q;
  logic [IdxW-1:0]     best_idx_q;
  logic [IdxW-1:0]     best_rank_q;
  logic                out_valid_q;
  logic                out_last_q;
  bpeb_pkg::entry_t    out_q;

  logic            issue;
  logic            mem_we;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] cand_rank;
  logic            cand_taken;
  logic            better;
  logic            take;
  logic            keep_new;
  logic            last_pending;

  assign issue        = cmd_i.scan_en && (scan_q < count_q);
  assign cand_rank    = rank_q[rd_idx_q];
  assign cand_taken   = cmd_i.find_max && taken_q[rd_idx_q];
  assign keep_new     = !(new_q.pri < best_q.pri);
  assign last_pending = ({1'b0, emit_cnt_q} + 1'b1) == {1'b0, count_q};

  // max for drain (newest wins ties), min for eviction (oldest wins ties)
  always_comb begin
    if (cmd_i.find_max) begin
      better = (rd_data_q.pri > best_q.pri) ||
               ((rd_data_q.pri == best_q.pri) && (cand_rank > best_rank_q));
    end else begin
      better = (rd_data_q.pri < best_q.pri) ||
               ((rd_data_q.pri == best_q.pri) && (cand_rank < best_rank_q));
    end
    take = rd_vld_q && !cand_taken && (!found_q || better);
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = count_q[IdxW-1:0];
    wr_data = '{pri: event_priority_i, start: start_time_i, stop: stop_time_i};
    if (cmd_i.append) begin
      mem_we = 1'b1;
    end else if (cmd_i.replace && keep_new) begin
      mem_we  = 1'b1;
      wr_addr = best_idx_q;
      wr_data = new_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ev_mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_q <= ev_mem[scan_q[IdxW-1:0]];
      rd_idx_q  <= scan_q[IdxW-1:0];
    end
    if (cmd_i.accept) begin
      new_q <= '{pri: event_priority_i, start: start_time_i, stop: stop_time_i};
    end
    if (take) begin
      best_q      <= rd_data_q;
      best_idx_q  <= rd_idx_q;
      best_rank_q <= cand_rank;
    end
    if (cmd_i.emit) begin
      out_q      <= best_q;
      out_last_q <= last_pending;
    end
  end

  // age ranks: new slot is newest, evicted slot's successors move down
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd_i.append && (count_q[IdxW-1:0] == IdxW'(i))) begin
        rank_q[i] <= count_q[IdxW-1:0];
      end else if (cmd_i.replace && keep_new) begin
        if (best_idx_q == IdxW'(i)) begin
          rank_q[i] <= TopRank;
        end else if (rank_q[i] > best_rank_q) begin
          rank_q[i] <= rank_q[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_q      <= '0;
      emit_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      taken_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.scan_clear) begin
        scan_q   <= '0;
        rd_vld_q <= 1'b0;
        found_q  <= 1'b0;
      end else begin
        rd_vld_q <= issue;
        if (issue) begin
          scan_q <= scan_q + 1'b1;
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.append) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.flush_start) begin
        taken_q    <= '0;
        emit_cnt_q <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q          <= 1'b1;
        taken_q[best_idx_q]  <= 1'b1;
        emit_cnt_q           <= emit_cnt_q + 1'b1;
        if (last_pending) begin
          count_q <= '0;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.full         = (count_q == FullCnt);
  assign sts_o.empty        = (count_q == '0);
  assign sts_o.scan_done    = (scan_q == count_q) && !rd_vld_q;
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;
  assign sts_o.last_pending = last_pending;

  assign out_valid_o    = out_valid_q;
  assign out_priority_o = out_q.pri;
  assign out_start_o    = out_q.start;
  assign out_stop_o     = out_q.stop;
  assign last_o         = out_last_q;

endmodule

// File: rtl/core/bounded_priority_event_buffer_unit.sv
// top level of the bounded priority event buffer
// Holds up to CAPACITY events (priority plus start and stop words).
// Input channel: in_valid_i / in_stall_o with cmd_i, event_priority_i,
// start_time_i and stop_time_i. cmd_i low adds an event, high drains.
// Output channel: out_valid_o / out_stall_i with out_priority_o,
// out_start_o, out_stop_o and last_o; a beat moves when valid is high and
// stall is low. One item is worked on at a time; in_stall_o is low only
// while the block is idle.
// An add to a store that is not full writes the next free slot. An add
// to a full store scans all CAPACITY slots through the single read port
// of the event memory; the lowest priority (oldest on ties) goes.
// A drain of n events repeats an n-slot scan for each result; results
// come out in decreasing priority, newest first on ties, last_o on the
// final beat. A drain of an empty store gives no beats.
// A stalled receiver holds the output register; the scan for the next
// beat goes on and waits for the register to free up.
// Reset empties the store and drops any beat not yet taken.
module bounded_priority_event_buffer_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic [bpeb_pkg::PriW-1:0]  event_priority_i,
  input  logic [bpeb_pkg::TimeW-1:0] start_time_i,
  input  logic [bpeb_pkg::TimeW-1:0] stop_time_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bpeb_pkg::PriW-1:0]  out_priority_o,
  output logic [bpeb_pkg::TimeW-1:0] out_start_o,
  output logic [bpeb_pkg::TimeW-1:0] out_stop_o,
  output logic                       last_o
);

  bpeb_pkg::dp_cmd_t dp_cmd;
  bpeb_pkg::dp_sts_t dp_sts;

  bpeb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  bpeb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .sts_o            (dp_sts),
    .event_priority_i (event_priority_i),
    .start_time_i     (start_time_i),
    .stop_time_i      (stop_time_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_priority_o   (out_priority_o),
    .out_start_o      (out_start_o),
    .out_stop_o       (out_stop_o),
    .last_o           (last_o)
  );

endmodule
